// ===== hdl/wcr_pkg.sv =====
// Shared types and constants for the weighted count redistributor.
`timescale 1ns / 1ps
`default_nettype none
package wcr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam logic [16:0] FULL_AREA = 17'd65536;
  localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
  localparam logic [10:0] LCG_MUL_HI = 11'h5DE;
  localparam logic [47:0] LCG_ADD = 48'hB;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DIST = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_UNUSED = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_BUNDLE_SIZE = 2'd1,
    CFG_RANDOM_SEED = 2'd2,
    CFG_NONE = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DIST,
    OP_CLEAR
  } queue_op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic [16:0] overlap_area;
    logic signed [23:0] count_value;
    logic count_valid;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_index;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [22:0] amount;
    logic table_overflow;
    logic last;
  } out_item_t;

  typedef struct packed {
    queue_op_t op;
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic [16:0] area;
    logic [22:0] count;
  } queue_item_t;

  typedef struct packed {
    logic valid;
    queue_item_t item;
  } queue_head_t;

endpackage
`default_nettype wire

// ===== hdl/weighted_count_redistributor_unit.sv =====
// Top level of the weighted count redistributor.
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy is low; busy rises only when the
// four-deep command queue is full. Results appear for one cycle with strobe high and
// cannot be held off. Add and clear commands are applied as they leave the queue. A
// distribute command leaves the queue, then per draw runs the generator step and the
// two-part product, a binary search whose steps each do a registered table read and a
// compare, a final read, and the tally read and write; then the output walk reads each
// table entry in turn and ends with a final step that emits the last tally.
module weighted_count_redistributor_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire wcr_pkg::in_item_t item,
  output logic strobe,
  output wcr_pkg::out_item_t result,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [47:0] cfg_data
);

  logic [12:0] image_width;
  logic [7:0] bundle_size;
  logic seed_load;
  logic pop;
  wcr_pkg::queue_head_t head;

  assign seed_load = cfg_we && (wcr_pkg::cfg_index_t'(cfg_index) == wcr_pkg::CFG_RANDOM_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1024;
      bundle_size <= 8'd4;
    end else if (cfg_we) begin
      unique case (wcr_pkg::cfg_index_t'(cfg_index))
        wcr_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        wcr_pkg::CFG_BUNDLE_SIZE: bundle_size <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  wcr_front u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .pop(pop),
    .head(head)
  );

  wcr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .pop(pop),
    .image_width(image_width),
    .bundle_size(bundle_size),
    .seed_load(seed_load),
    .seed_value(cfg_data),
    .strobe(strobe),
    .result(result)
  );

endmodule
`default_nettype wire

// ===== hdl/wcr_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module wcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/wcr_front.sv =====
// Command intake: classifies transactions and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module wcr_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire wcr_pkg::in_item_t item,
  input wire logic pop,
  output wcr_pkg::queue_head_t head
);

  wcr_pkg::queue_item_t slots [wcr_pkg::QUEUE_DEPTH];
  logic [wcr_pkg::QPTR_W-1:0] wptr;
  logic [wcr_pkg::QPTR_W-1:0] rptr;
  logic [wcr_pkg::QPTR_W:0] fill;
  wcr_pkg::queue_item_t cls;
  logic keep;
  logic push;

  always_comb begin
    cls.pix_x = item.pix_x;
    cls.pix_y = item.pix_y;
    cls.area = (item.overlap_area > wcr_pkg::FULL_AREA) ? wcr_pkg::FULL_AREA
                                                         : item.overlap_area;
    cls.count = item.count_value[22:0];
    cls.op = wcr_pkg::OP_CLEAR;
    keep = 1'b0;
    unique case (wcr_pkg::command_t'(item.command))
      wcr_pkg::CMD_ADD: begin
        cls.op = wcr_pkg::OP_ADD;
        keep = (cls.area != 17'd0);
      end
      wcr_pkg::CMD_DIST: begin
        keep = 1'b1;
        if (item.count_valid && !item.count_value[23] && item.count_value != 24'sd0) begin
          cls.op = wcr_pkg::OP_DIST;
        end
      end
      wcr_pkg::CMD_CLEAR: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy = (fill == (wcr_pkg::QPTR_W + 1)'(wcr_pkg::QUEUE_DEPTH));
  assign push = start && !busy && keep;
  assign head.valid = (fill != '0);
  assign head.item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
    if (push) begin
      slots[wptr] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> fill != '0)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== hdl/wcr_back.sv =====
// Redistribution engine: table loading, weighted draws and tally output.
`timescale 1ns / 1ps
`default_nettype none
module wcr_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire wcr_pkg::queue_head_t head,
  output logic pop,
  input wire logic [12:0] image_width,
  input wire logic [7:0] bundle_size,
  input wire logic seed_load,
  input wire logic [47:0] seed_value,
  output logic strobe,
  output wcr_pkg::out_item_t result
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 17;
  localparam int unsigned EW = 24 + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_LCG0, S_LCG1, S_LCG2, S_MUL0, S_MUL1, S_SRCH_RD, S_SRCH_CMP,
    S_TALLY_RD, S_TALLY_WR, S_EMIT_RD, S_EMIT_DATA, S_EMIT_LAST
  } state_t;

  state_t state;
  logic [AW:0] entry_count;
  logic [CW-1:0] total_area;
  logic overflow_flag;
  logic [47:0] gen;
  logic [47:0] p0;
  logic [23:0] t24;
  logic [EW-1:0] ph;
  logic [48+CW-1:0] prod;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] k;
  logic [22:0] cnt;
  logic [23:0] done;
  logic [7:0] step;
  logic have_pend;
  wcr_pkg::out_item_t pend;
  wcr_pkg::out_item_t pend_next;
  wcr_pkg::out_item_t pend_last;

  logic [AW:0] mid_sum;
  logic [AW-1:0] mid;
  logic [7:0] bs_eff;
  logic [CW-1:0] area_ext;
  logic [CW-1:0] cum_rd;
  logic [23:0] done_next;
  logic le;

  logic e_we;
  logic [AW-1:0] e_raddr;
  logic [24+CW-1:0] e_rdata;
  logic t_we;
  logic [AW-1:0] t_waddr;
  logic [22:0] t_wdata;
  logic [AW-1:0] t_raddr;
  logic [22:0] t_rdata;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[AW:1];
  assign bs_eff = (bundle_size == 8'd0) ? 8'd1 : bundle_size;
  assign area_ext = CW'(head.item.area);
  assign cum_rd = e_rdata[CW-1:0];
  assign done_next = done + {16'd0, step};
  assign le = (prod[48+CW-1:48] < cum_rd) ||
              ((prod[48+CW-1:48] == cum_rd) && (prod[47:0] == 48'd0));
  assign pop = (state == S_IDLE) && head.valid;

  always_comb begin
    pend_next.pixel_index = 24'({13'd0, e_rdata[24+CW-1:12+CW]} +
                                e_rdata[12+CW-1:CW] * image_width);
    pend_next.out_x = e_rdata[24+CW-1:12+CW];
    pend_next.out_y = e_rdata[12+CW-1:CW];
    pend_next.amount = t_rdata;
    pend_next.table_overflow = overflow_flag;
    pend_next.last = 1'b0;
    pend_last = pend;
    pend_last.last = 1'b1;
  end

  always_comb begin
    e_we = 1'b0;
    t_we = 1'b0;
    t_waddr = entry_count[AW-1:0];
    t_wdata = 23'd0;
    e_raddr = k;
    t_raddr = k;
    unique case (state)
      S_IDLE: begin
        if (pop && head.item.op == wcr_pkg::OP_ADD &&
            entry_count != (AW + 1)'(TABLE_DEPTH)) begin
          e_we = 1'b1;
          t_we = 1'b1;
        end
      end
      S_SRCH_RD: e_raddr = mid;
      S_TALLY_RD: t_raddr = lo;
      S_TALLY_WR: begin
        t_we = 1'b1;
        t_waddr = lo;
        t_wdata = t_rdata + {15'd0, step};
      end
      S_EMIT_DATA: begin
        t_we = 1'b1;
        t_waddr = k;
      end
      default: begin
      end
    endcase
  end

  wcr_ram #(.WIDTH(24 + CW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk(clk),
    .we(e_we),
    .waddr(entry_count[AW-1:0]),
    .wdata({head.item.pix_x, head.item.pix_y, total_area + area_ext}),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  wcr_ram #(.WIDTH(23), .DEPTH(TABLE_DEPTH)) u_tally_ram (
    .clk(clk),
    .we(t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      total_area <= '0;
      overflow_flag <= 1'b0;
      gen <= '0;
      have_pend <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (seed_load) begin
        gen <= seed_value;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.item.op)
              wcr_pkg::OP_ADD: begin
                if (entry_count == (AW + 1)'(TABLE_DEPTH)) begin
                  overflow_flag <= 1'b1;
                end else begin
                  entry_count <= entry_count + 1'b1;
                  total_area <= total_area + area_ext;
                end
              end
              wcr_pkg::OP_DIST: begin
                if (entry_count == '0) begin
                  total_area <= '0;
                end else begin
                  cnt <= head.item.count;
                  done <= '0;
                  state <= S_LCG0;
                end
              end
              default: begin
                entry_count <= '0;
                total_area <= '0;
              end
            endcase
          end
        end
        S_LCG0: begin
          step <= ((done + {16'd0, bs_eff}) > {1'b0, cnt}) ? 8'd1 : bs_eff;
          p0 <= gen[23:0] * wcr_pkg::LCG_MUL_LO;
          state <= S_LCG1;
        end
        S_LCG1: begin
          t24 <= 24'(gen[23:0] * wcr_pkg::LCG_MUL_HI);
          state <= S_LCG2;
        end
        S_LCG2: begin
          gen <= p0 + {t24 + 24'(gen[47:24] * wcr_pkg::LCG_MUL_LO), 24'd0}
                 + wcr_pkg::LCG_ADD;
          state <= S_MUL0;
        end
        S_MUL0: begin
          ph <= gen[47:24] * total_area;
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod <= {ph, 24'd0} + (48 + CW)'(gen[23:0] * total_area);
          lo <= '0;
          hi <= AW'(entry_count - 1'b1);
          state <= S_SRCH_RD;
        end
        S_SRCH_RD: begin
          state <= (lo == hi) ? S_TALLY_RD : S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (le) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
          state <= S_SRCH_RD;
        end
        S_TALLY_RD: state <= S_TALLY_WR;
        S_TALLY_WR: begin
          done <= done_next;
          if (done_next >= {1'b0, cnt}) begin
            k <= '0;
            have_pend <= 1'b0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_LCG0;
          end
        end
        S_EMIT_RD: state <= S_EMIT_DATA;
        S_EMIT_DATA: begin
          if (t_rdata != 23'd0) begin
            if (have_pend) begin
              strobe <= 1'b1;
              result <= pend;
            end
            have_pend <= 1'b1;
            pend <= pend_next;
          end
          k <= k + 1'b1;
          state <= ({1'b0, k} == entry_count - 1'b1) ? S_EMIT_LAST : S_EMIT_RD;
        end
        S_EMIT_LAST: begin
          if (have_pend) begin
            strobe <= 1'b1;
            result <= pend_last;
          end
          have_pend <= 1'b0;
          entry_count <= '0;
          total_area <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= (AW + 1)'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_amount_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> result.amount != 23'd0)
    else $error("tally of zero emitted");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> state == S_IDLE && entry_count == '0)
    else $error("final tally emitted before table clear");
`endif

endmodule
`default_nettype wire

// ===== sim/weighted_count_redistributor_unit_tb.sv =====
// Self-checking testbench for the weighted count redistributor with its own tally predictor.
`timescale 1ns / 1ps
module weighted_count_redistributor_unit_tb;

  localparam int TABLE_SIZE = 64;
  localparam int CYCLE_LIMIT = 100000000;
  localparam int SETTLE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  wcr_pkg::in_item_t item = '0;
  logic strobe;
  wcr_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = wcr_pkg::CFG_NONE;
  logic [47:0] cfg_data = '0;

  weighted_count_redistributor_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [12:0] row_len = 13'd1024;
  logic [7:0] bundle = 8'd4;
  logic [47:0] lcg = '0;
  logic [11:0] col_tab [TABLE_SIZE];
  logic [11:0] row_tab [TABLE_SIZE];
  logic [22:0] area_sums [TABLE_SIZE];
  logic [22:0] tally [TABLE_SIZE];
  int n_entries = 0;
  logic overflow = 1'b0;

  wcr_pkg::in_item_t item_backlog[$];
  wcr_pkg::out_item_t tallies_due[$];
  int fails = 0;
  int cycles = 0;
  logic took = 1'b0;
  logic quiet = 1'b0;
  int gap = 0;

  function automatic int pick_entry(logic [47:0] x);
    logic [95:0] lhs;
    logic [95:0] rhs;
    lhs = 96'(x) * 96'(area_sums[n_entries - 1]);
    for (int k = 0; k < n_entries - 1; k++) begin
      rhs = {25'd0, area_sums[k], 48'd0};
      if (lhs <= rhs) return k;
    end
    return n_entries - 1;
  endfunction

  task automatic clear_entries();
    n_entries = 0;
    for (int k = 0; k < TABLE_SIZE; k++) tally[k] = '0;
  endtask

  task automatic redistribute_item(wcr_pkg::in_item_t t);
    logic [16:0] a;
    logic [22:0] cnt;
    logic [22:0] done;
    logic [22:0] step;
    wcr_pkg::out_item_t o;
    int last_k;
    case (wcr_pkg::command_t'(t.command))
      wcr_pkg::CMD_ADD: begin
        a = (t.overlap_area > wcr_pkg::FULL_AREA) ? wcr_pkg::FULL_AREA : t.overlap_area;
        if (a != 0) begin
          if (n_entries >= TABLE_SIZE) begin
            overflow = 1'b1;
          end else begin
            col_tab[n_entries] = t.pix_x;
            row_tab[n_entries] = t.pix_y;
            area_sums[n_entries] = 23'(a) + (n_entries ? area_sums[n_entries - 1] : 23'd0);
            n_entries++;
          end
        end
      end
      wcr_pkg::CMD_CLEAR: clear_entries();
      wcr_pkg::CMD_DIST: begin
        cnt = t.count_value[22:0];
        if (t.count_valid && !t.count_value[23] && cnt != 0 && n_entries != 0) begin
          step = (bundle == 0) ? 23'd1 : 23'(bundle);
          done = '0;
          while (done < cnt) begin
            if (24'(done) + 24'(step) > 24'(cnt)) step = 23'd1;
            lcg = lcg * 48'h5DEECE66D + wcr_pkg::LCG_ADD;
            tally[pick_entry(lcg)] += step;
            done += step;
          end
          last_k = -1;
          for (int k = 0; k < n_entries; k++) if (tally[k] != 0) last_k = k;
          for (int k = 0; k < n_entries; k++) begin
            if (tally[k] != 0) begin
              o.pixel_index = 24'(32'(col_tab[k]) + 32'(row_tab[k]) * 32'(row_len));
              o.out_x = col_tab[k];
              o.out_y = row_tab[k];
              o.amount = tally[k];
              o.table_overflow = overflow;
              o.last = (k == last_k);
              tallies_due.push_back(o);
            end
          end
        end
        clear_entries();
      end
      default: ;
    endcase
  endtask

  // Acceptance, configuration tracking and result checking.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    took <= !rst && start && !busy;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          wcr_pkg::CFG_IMAGE_WIDTH: row_len = cfg_data[12:0];
          wcr_pkg::CFG_BUNDLE_SIZE: bundle = cfg_data[7:0];
          wcr_pkg::CFG_RANDOM_SEED: lcg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        redistribute_item(item);
      end
      if (strobe) begin
        if (tallies_due.size() == 0) begin
          $error("unexpected tally transaction %p", result);
          fails++;
        end else begin
          wcr_pkg::out_item_t e;
          e = tallies_due.pop_front();
          if (result.pixel_index !== e.pixel_index) begin
            $error("pixel_index expected %0d actual %0d", e.pixel_index, result.pixel_index);
            fails++;
          end
          if (result.out_x !== e.out_x) begin
            $error("out_x expected %0d actual %0d", e.out_x, result.out_x);
            fails++;
          end
          if (result.out_y !== e.out_y) begin
            $error("out_y expected %0d actual %0d", e.out_y, result.out_y);
            fails++;
          end
          if (result.amount !== e.amount) begin
            $error("amount expected %0d actual %0d", e.amount, result.amount);
            fails++;
          end
          if (result.table_overflow !== e.table_overflow) begin
            $error("table_overflow expected %0d actual %0d", e.table_overflow,
                   result.table_overflow);
            fails++;
          end
          if (result.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, result.last);
            fails++;
          end
        end
      end
    end
  end

  // Command driver.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      gap <= $urandom_range(1, 17) - 1;
      start <= 1'b0;
    end else if (item_backlog.size() != 0) begin
      item <= item_backlog.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_cmd(wcr_pkg::command_t c, logic [11:0] x, logic [11:0] y,
                          logic [16:0] a, logic [23:0] cnt, logic v);
    wcr_pkg::in_item_t t;
    t.command = c;
    t.pix_x = x;
    t.pix_y = y;
    t.overlap_area = a;
    t.count_value = cnt;
    t.count_valid = v;
    item_backlog.push_back(t);
  endtask

  task automatic push_add(logic [16:0] a);
    push_cmd(wcr_pkg::CMD_ADD, 12'($urandom), 12'($urandom), a, 24'($urandom),
             1'($urandom));
  endtask

  task automatic push_dist(logic [23:0] cnt, logic v);
    push_cmd(wcr_pkg::CMD_DIST, 12'($urandom), 12'($urandom), 17'($urandom), cnt, v);
  endtask

  task automatic wait_idle();
    while (item_backlog.size() != 0 || start || tallies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(wcr_pkg::cfg_index_t idx, logic [47:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n_items);
    int made;
    int r;
    int n_add;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        push_cmd(wcr_pkg::command_t'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                 17'($urandom), 24'($urandom), 1'($urandom));
        made++;
      end else if (r == 1) begin
        case ($urandom_range(0, 2))
          0: push_dist(24'($urandom), 1'b0);
          1: push_dist(24'($urandom) | 24'h800000, 1'b1);
          default: push_dist(24'd0, 1'b1);
        endcase
        made++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          push_cmd(wcr_pkg::CMD_CLEAR, 12'($urandom), 12'($urandom), 17'($urandom),
                   24'($urandom), 1'($urandom));
          made++;
        end
        n_add = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        for (int k = 0; k < n_add; k++) begin
          case ($urandom_range(0, 9))
            0: push_add(17'd0);
            1: push_add(17'($urandom_range(65536, 131071)));
            default: push_add(17'($urandom_range(1, 65536)));
          endcase
        end
        made += n_add;
        if ($urandom_range(0, 9) == 0) push_dist(24'($urandom_range(1, 4000)), 1'b1);
        else push_dist(24'($urandom_range(1, 300)), 1'b1);
        made++;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    push_cmd(wcr_pkg::CMD_CLEAR, 12'd0, 12'd0, 17'd0, 24'd0, 1'b0);
    push_cmd(wcr_pkg::CMD_ADD, 12'd0, 12'd0, 17'd1, 24'd0, 1'b0);
    push_cmd(wcr_pkg::CMD_ADD, 12'd4095, 12'd4095, 17'd65536, 24'hFFFFFF, 1'b1);
    push_cmd(wcr_pkg::CMD_ADD, 12'd123, 12'd45, 17'd131071, 24'd0, 1'b0);
    push_cmd(wcr_pkg::CMD_ADD, 12'd7, 12'd7, 17'd0, 24'd0, 1'b0);
    push_cmd(wcr_pkg::CMD_UNUSED, 12'd4095, 12'd4095, 17'd131071, 24'd5, 1'b1);
    push_dist(24'd50, 1'b1);
    push_dist(24'd5, 1'b1);
    push_add(17'd100);
    push_dist(24'h7FFFFF, 1'b0);
    push_add(17'd300);
    push_dist(24'h800000, 1'b1);
    push_add(17'd300);
    push_dist(24'd0, 1'b1);
    push_add(17'd5);
    push_cmd(wcr_pkg::CMD_CLEAR, 12'd1, 12'd1, 17'd1, 24'd1, 1'b1);
    push_dist(24'd5, 1'b1);
    push_add(17'd65536);
    push_add(17'd1);
    push_dist(24'd3, 1'b1);
    wait_idle();

    write_reg(wcr_pkg::CFG_BUNDLE_SIZE, 48'd255);
    write_reg(wcr_pkg::CFG_IMAGE_WIDTH, 48'd4096);
    write_reg(wcr_pkg::CFG_RANDOM_SEED, 48'hFFFFFFFFFFFF);
    push_cmd(wcr_pkg::CMD_ADD, 12'd4095, 12'd4095, 17'd40000, 24'd0, 1'b0);
    push_dist(24'h7FFFFF, 1'b1);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p % 3)
        0: write_reg(wcr_pkg::CFG_IMAGE_WIDTH, 48'd1);
        1: write_reg(wcr_pkg::CFG_IMAGE_WIDTH, 48'd4096);
        default: write_reg(wcr_pkg::CFG_IMAGE_WIDTH, 48'($urandom_range(1, 4096)));
      endcase
      case (p % 4)
        0: write_reg(wcr_pkg::CFG_BUNDLE_SIZE, 48'd1);
        1: write_reg(wcr_pkg::CFG_BUNDLE_SIZE, 48'd255);
        2: write_reg(wcr_pkg::CFG_BUNDLE_SIZE, 48'd0);
        default: write_reg(wcr_pkg::CFG_BUNDLE_SIZE, 48'($urandom_range(1, 16)));
      endcase
      case (p % 3)
        0: write_reg(wcr_pkg::CFG_RANDOM_SEED, 48'd0);
        1: write_reg(wcr_pkg::CFG_RANDOM_SEED, 48'hFFFFFFFFFFFF);
        default: write_reg(wcr_pkg::CFG_RANDOM_SEED, {16'($urandom), 32'($urandom)});
      endcase
      if (p == 9) quiet = 1'b1;
      random_phase(44);
      wait_idle();
    end

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
